@@ src/assert_macros.svh @@
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge outside reset.
`define NQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`endif

@@ src/nqse_pkg.sv @@
// Shared constants for the N-queens search block.
`timescale 1ns / 1ps
package nqse_pkg;
  localparam int MaxSizeDef = 16;
  localparam int BoardW     = 5;
  localparam logic [BoardW-1:0] BoardRst = 5'd8;
  localparam int NibW       = 4;
  localparam int CountW     = 24;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
endpackage

@@ src/nqse_cell.sv @@
// One row cell: holds the chosen column of its row, joins the read and packing chains.
`timescale 1ns / 1ps
module nqse_cell import nqse_pkg::*; #(
  parameter int MAX_SIZE = MaxSizeDef,
  parameter int IDX      = 0,
  localparam int CIW     = $clog2(MAX_SIZE),
  localparam int RW      = $clog2(MAX_SIZE + 1)
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [CIW-1:0]          wr_row_i,
  input  logic [CIW-1:0]          wr_col_i,
  input  logic [RW-1:0]           n_i,
  input  logic [CIW-1:0]          rd_row_i,
  input  logic [CIW-1:0]          rd_i,
  output logic [CIW-1:0]          rd_o,
  input  logic [NibW*MAX_SIZE-1:0] packed_i,
  output logic [NibW*MAX_SIZE-1:0] packed_o
);
  logic [CIW-1:0] col_q;
  logic           hit;
  logic [CIW-1:0] col_eff;

  assign hit = wr_en_i && (wr_row_i == CIW'(IDX));

  // column store, no reset needed
  always_ff @(posedge clk_i) begin
    if (hit) begin
      col_q <= wr_col_i;
    end
  end

  // read chain picks this row's column on a match
  assign rd_o = (rd_row_i == CIW'(IDX)) ? col_q : rd_i;

  // packing chain, with bypass of a write in this cycle
  assign col_eff = hit ? wr_col_i : col_q;
  always_comb begin
    packed_o = packed_i;
    if (RW'(IDX) < n_i) begin
      packed_o[NibW*IDX +: NibW] = NibW'(col_eff);
    end
  end
endmodule

@@ src/n_queens_solution_enumerator_unit.sv @@
// Top level of the N-queens backtracking solution enumerator.
// Usage:
//  - Input channel (in_valid_i, in_stall_o, restart_i): one beat is one request.
//    restart_i = 1 clears the search and the count, 0 resumes it.
//  - Output channel (out_valid_o, out_stall_i): one result beat per request with
//    found_o, queen_columns_o (4 bits per row) and solution_number_o.
//  - Config channel (cfg_valid_i, cfg_ready_o, board_size_i): writes N and
//    clears the search and the count; accepted while no request is in progress.
//  - Timing: the search takes one placement step per cycle; out_valid_o rises
//    in the cycle after the step that finds a solution or exhausts the search,
//    or in the cycle after the request beat when it is exhausted and restart_i is 0.
//    Each step tries, places or removes one queen. Steps are data dependent.
//  - One request at a time; a new one is taken as soon as the search engine
//    is idle and the output register can take its result.
//  - Reset: N = 8, empty board, count zero. The row stack has no reset.
//  - Stall on the output holds the result and holds off the next request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module n_queens_solution_enumerator_unit import nqse_pkg::*; #(
  parameter int MAX_SIZE = MaxSizeDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [BoardW-1:0]          board_size_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [NibW*MAX_SIZE-1:0]   queen_columns_o,
  output logic [CountW-1:0]          solution_number_o
);
  localparam int CIW = $clog2(MAX_SIZE);
  localparam int RW  = $clog2(MAX_SIZE + 1);
  localparam int DW  = 2 * MAX_SIZE - 1;
  localparam int DIW = $clog2(DW);
  localparam int PW  = NibW * MAX_SIZE;

  typedef enum logic {ST_IDLE, ST_SEARCH} state_e;

  state_e              state_q, state_d;
  logic [BoardW-1:0]   bsize_q, bsize_d;
  logic [MAX_SIZE-1:0] colf_q, colf_d;
  logic [DW-1:0]       ldf_q, ldf_d, rdf_q, rdf_d;
  logic [RW-1:0]       row_q, row_d, c_q, c_d;
  logic                done_q, done_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic                ov_q, ov_d, fnd_q, fnd_d;
  logic [PW-1:0]       qc_q, qc_d;
  logic [CountW-1:0]   num_q, num_d;

  logic [RW-1:0]  n_eff;
  logic           out_free, in_acc, cfg_acc;
  logic           pop, place, is_free;
  logic [RW-1:0]  row_m1;
  logic [CIW-1:0] sq_row, sq_col, rd_col;
  logic [DIW-1:0] ldi, rdi;
  logic [PW-1:0]  packed_w;

  // chain wires
  logic [CIW-1:0] rd_ch [MAX_SIZE+1];
  logic [PW-1:0]  pk_ch [MAX_SIZE+1];

  // board size clamp
  always_comb begin
    if (bsize_q == '0) begin
      n_eff = RW'(1);
    end else if (int'(bsize_q) > MAX_SIZE) begin
      n_eff = RW'(MAX_SIZE);
    end else begin
      n_eff = RW'(bsize_q);
    end
  end

  assign out_free    = !ov_q || !out_stall_i;
  assign in_stall_o  = !(state_q == ST_IDLE && out_free);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // square under test: top queen on a pop, candidate otherwise
  assign row_m1 = row_q - RW'(1);
  assign pop    = (state_q == ST_SEARCH) && out_free && (c_q >= n_eff) && (row_q != '0);
  assign sq_row = pop ? row_m1[CIW-1:0] : row_q[CIW-1:0];
  assign sq_col = pop ? rd_col : c_q[CIW-1:0];
  assign ldi    = DIW'(sq_row) + DIW'(sq_col);
  assign rdi    = DIW'(sq_row) + DIW'(MAX_SIZE - 1) - DIW'(sq_col);
  assign is_free = colf_q[sq_col] && ldf_q[ldi] && rdf_q[rdi];
  assign place  = (state_q == ST_SEARCH) && out_free && (c_q < n_eff) && is_free;

  // row cell chain
  assign rd_ch[0] = '0;
  assign pk_ch[0] = '0;
  for (genvar g = 0; g < MAX_SIZE; g++) begin : g_cell
    nqse_cell #(.MAX_SIZE(MAX_SIZE), .IDX(g)) u_cell (
      .clk_i    (clk_i),
      .wr_en_i  (place),
      .wr_row_i (sq_row),
      .wr_col_i (sq_col),
      .n_i      (n_eff),
      .rd_row_i (sq_row),
      .rd_i     (rd_ch[g]),
      .rd_o     (rd_ch[g+1]),
      .packed_i (pk_ch[g]),
      .packed_o (pk_ch[g+1])
    );
  end
  assign rd_col   = rd_ch[MAX_SIZE];
  assign packed_w = pk_ch[MAX_SIZE];

  // search step and handshakes
  always_comb begin
    state_d = state_q;
    bsize_d = bsize_q;
    colf_d  = colf_q;
    ldf_d   = ldf_q;
    rdf_d   = rdf_q;
    row_d   = row_q;
    c_d     = c_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q;
    fnd_d   = fnd_q;
    qc_d    = qc_q;
    num_d   = num_q;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    if (cfg_acc) begin
      bsize_d = board_size_i;
      colf_d  = '1;
      ldf_d   = '1;
      rdf_d   = '1;
      row_d   = '0;
      done_d  = 1'b0;
      cnt_d   = '0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (restart_i) begin
            colf_d = '1;
            ldf_d  = '1;
            rdf_d  = '1;
            row_d  = '0;
            done_d = 1'b0;
            cnt_d  = '0;
          end
          if (done_q && !restart_i) begin
            ov_d  = 1'b1;
            fnd_d = 1'b0;
            qc_d  = '0;
            num_d = cnt_q;
          end else begin
            state_d = ST_SEARCH;
            // resume after a solution: force a pop of the last queen
            if (!restart_i && row_q >= n_eff && row_q != '0) begin
              c_d = n_eff;
            end else begin
              c_d = '0;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (out_free) begin
          if (c_q >= n_eff) begin
            if (row_q == '0) begin
              done_d  = 1'b1;
              ov_d    = 1'b1;
              fnd_d   = 1'b0;
              qc_d    = '0;
              num_d   = cnt_q;
              state_d = ST_IDLE;
            end else begin
              // backtrack one row
              row_d         = row_m1;
              colf_d[sq_col] = 1'b1;
              ldf_d[ldi]    = 1'b1;
              rdf_d[rdi]    = 1'b1;
              c_d           = RW'(rd_col) + RW'(1);
            end
          end else if (is_free) begin
            colf_d[sq_col] = 1'b0;
            ldf_d[ldi]    = 1'b0;
            rdf_d[rdi]    = 1'b0;
            row_d         = row_q + RW'(1);
            c_d           = '0;
            if (row_q + RW'(1) >= n_eff) begin
              cnt_d   = (cnt_q == CountMax) ? cnt_q : cnt_q + CountW'(1);
              ov_d    = 1'b1;
              fnd_d   = 1'b1;
              qc_d    = packed_w;
              num_d   = (cnt_q == CountMax) ? cnt_q : cnt_q + CountW'(1);
              state_d = ST_IDLE;
            end
          end else begin
            c_d = c_q + RW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bsize_q <= BoardRst;
      colf_q  <= '1;
      ldf_q   <= '1;
      rdf_q   <= '1;
      row_q   <= '0;
      c_q     <= '0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      bsize_q <= bsize_d;
      colf_q  <= colf_d;
      ldf_q   <= ldf_d;
      rdf_q   <= rdf_d;
      row_q   <= row_d;
      c_q     <= c_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fnd_q <= fnd_d;
    qc_q  <= qc_d;
    num_q <= num_d;
  end

  assign out_valid_o       = ov_q;
  assign found_o           = fnd_q;
  assign queen_columns_o   = qc_q;
  assign solution_number_o = num_q;

  // checks
  `NQ_ASSERT(a_row_bound, row_q <= RW'(MAX_SIZE), "row count beyond board")
  `NQ_ASSERT(a_done_empty, done_q |-> (row_q == '0), "exhausted search with queens placed")
  `NQ_ASSERT(a_start_search, (in_acc && !done_q) |=> (state_q == ST_SEARCH || ov_q),
             "request did not start a search")
endmodule
